/* src/fdt_pkg.sv */
// fdt_pkg: shared constants for the factorial divisibility test
// no dependencies
package fdt_pkg;
  localparam int OPERAND_BITS_DEF = 31;
endpackage

/* src/fdt_serial_div.sv */
// fdt_serial_div: bit-serial restoring divider, one quotient bit per cycle
// depends on fdt_pkg
module fdt_serial_div #(
  parameter int OPERAND_BITS = fdt_pkg::OPERAND_BITS_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    go,
  input  logic [OPERAND_BITS-1:0] dividend,
  input  logic [OPERAND_BITS-1:0] divisor,
  output logic                    done,
  output logic [OPERAND_BITS-1:0] quotient,
  output logic [OPERAND_BITS-1:0] remainder
);
  import fdt_pkg::*;
  localparam int W  = OPERAND_BITS;
  localparam int CW = $clog2(W + 1);

  logic [W-1:0]  shreg;
  logic [W-1:0]  part;
  logic [CW-1:0] cnt;
  logic          run;
  logic [W:0]    trial;
  logic [W:0]    diff;

  assign trial = {part, shreg[W-1]};
  assign diff  = trial - {1'b0, divisor};
  assign quotient  = shreg;
  assign remainder = part;

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (go) begin
        run   <= 1'b1;
        cnt   <= CW'(W);
        shreg <= dividend;
        part  <= '0;
      end else if (run) begin
        if (!diff[W]) begin
          part  <= diff[W-1:0];
          shreg <= {shreg[W-2:0], 1'b1};
        end else begin
          part  <= trial[W-1:0];
          shreg <= {shreg[W-2:0], 1'b0};
        end
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule

/* src/factorial_divisibility_test_core.sv */
// factorial_divisibility_test_core: does m divide n factorial
// trial division plus legendre sums on one shared serial divider
// a beat takes as many divides on the serial divider as it needs: up to
// ~sqrt(m)/2 trial divides and a few per prime factor; m = 0 needs no divide
// one beat at a time: busy is high from acceptance until the done strobe (never for m = 0)
// rst is synchronous, active high; it returns the sequencer to idle
module factorial_divisibility_test_core #(
  parameter int OPERAND_BITS = fdt_pkg::OPERAND_BITS_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  output logic                    busy,
  input  logic [OPERAND_BITS-1:0] n_value,
  input  logic [OPERAND_BITS-1:0] m_value,
  output logic                    done,
  output logic                    divides
);
  import fdt_pkg::*;
  localparam int W  = OPERAND_BITS;
  localparam int KW = $clog2(W + 1);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_TEST  = 2'd1;
  localparam logic [1:0] S_STRIP = 2'd2;
  localparam logic [1:0] S_LEG   = 2'd3;

  logic [1:0]    state;
  logic [W-1:0]  n, rem, d, total, div_a;
  logic [KW-1:0] k;
  logic          div_go, div_done;
  logic [W-1:0]  q, r, d_next, tot;

  fdt_serial_div #(.OPERAND_BITS(OPERAND_BITS)) u_div (
    .clk(clk), .rst(rst), .go(div_go), .dividend(div_a), .divisor(d),
    .done(div_done), .quotient(q), .remainder(r)
  );

  assign busy   = (state != S_IDLE);
  assign d_next = (d == W'(2)) ? W'(3) : d + W'(2);
  assign tot    = total + q;

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      div_go <= 1'b0;
      done   <= 1'b0;
    end else begin
      div_go <= 1'b0;
      done   <= 1'b0;
      case (state)
        S_IDLE: begin
          if (start) begin
            n   <= n_value;
            rem <= m_value;
            if (m_value == '0) begin
              done    <= 1'b1;
              divides <= 1'b0;
            end else begin
              d      <= W'(2);
              div_a  <= m_value;
              div_go <= 1'b1;
              state  <= S_TEST;
            end
          end
        end
        S_TEST: begin
          if (div_done) begin
            if (d > q) begin
              done    <= 1'b1;
              divides <= !((rem > W'(1)) && (n < rem));
              state   <= S_IDLE;
            end else if (r == '0) begin
              rem    <= q;
              k      <= KW'(1);
              div_a  <= q;
              div_go <= 1'b1;
              state  <= S_STRIP;
            end else begin
              d      <= d_next;
              div_a  <= rem;
              div_go <= 1'b1;
            end
          end
        end
        S_STRIP: begin
          if (div_done) begin
            div_go <= 1'b1;
            if (r == '0) begin
              rem   <= q;
              k     <= k + 1'b1;
              div_a <= q;
            end else begin
              total <= '0;
              div_a <= n;
              state <= S_LEG;
            end
          end
        end
        S_LEG: begin
          if (div_done) begin
            if (tot >= W'(k)) begin
              d      <= d_next;
              div_a  <= rem;
              div_go <= 1'b1;
              state  <= S_TEST;
            end else if (q == '0) begin
              done    <= 1'b1;
              divides <= 1'b0;
              state   <= S_IDLE;
            end else begin
              total  <= tot;
              div_a  <= q;
              div_go <= 1'b1;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

/* src/fdt_checker.sv */
// fdt_checker: port-level assertions for the core, bound into factorial_divisibility_test_core
// depends on fdt_pkg and factorial_divisibility_test_core
module fdt_checker (
  input logic clk,
  input logic rst,
  input logic start,
  input logic busy,
  input logic done
);
  import fdt_pkg::*;

  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy) || $past(start)) else $error("strobe without a beat");
  a_busy_on_accept: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> (busy || done)) else $error("accept not taken");
  a_idle_after_done: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy) else $error("busy after done");
endmodule

bind factorial_divisibility_test_core fdt_checker u_fdt_checker (
  .clk(clk), .rst(rst), .start(start), .busy(busy), .done(done)
);

/* sim/factorial_divisibility_test_core_test.sv */
// factorial_divisibility_test_core_test: self-checking bench for the factorial divisibility core
// directed table then random n/m pairs, checked by known answer or legendre-formula predictor
// depends on fdt_pkg and factorial_divisibility_test_core
module factorial_divisibility_test_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int W = fdt_pkg::OPERAND_BITS_DEF;
  localparam longint unsigned OP_MAX = (64'd1 << W) - 1;
  localparam int STALL_LIMIT = 3000000;
  localparam int DRAIN_CYCLES = 200;
  localparam int RANDOM_BEATS = 80;

  typedef struct {
    logic [W-1:0] n;
    logic [W-1:0] m;
    bit           known;
    bit           answer;
  } divisibility_row_t;

  logic         clk;
  logic         rst;
  logic         start;
  logic         busy;
  logic [W-1:0] n_value;
  logic [W-1:0] m_value;
  logic         done;
  logic         divides;

  bit pending_answers[$];
  int mismatches = 0;
  int idle_pct = 0;
  int stall_count = 0;

  factorial_divisibility_test_core #(.OPERAND_BITS(W)) DUT (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .n_value(n_value), .m_value(m_value), .done(done), .divides(divides)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic longint unsigned legendre_exponent(input longint unsigned n,
                                                        input longint unsigned p);
    longint unsigned total;
    longint unsigned pw;
    total = 0;
    pw = p;
    if (p < 2 || pw > n) return 0;
    forever begin
      total += n / pw;
      if (pw > n / p) break;
      pw *= p;
    end
    return total;
  endfunction

  function automatic bit strip_factor_ok(input longint unsigned n, input longint unsigned d,
                                         inout longint unsigned rem);
    longint unsigned k;
    k = 0;
    while (rem % d == 0) begin
      rem /= d;
      k++;
    end
    if (k == 0) return 1'b1;
    return legendre_exponent(n, d) >= k;
  endfunction

  function automatic bit factorial_divisible(input longint unsigned n, input longint unsigned m);
    longint unsigned rem;
    longint unsigned d;
    bit ok;
    rem = m;
    ok = 1'b1;
    if (rem == 0) return 1'b0;
    if (rem >= 4 && !strip_factor_ok(n, 2, rem)) ok = 1'b0;
    for (d = 3; ok && d <= rem / d; d += 2)
      if (!strip_factor_ok(n, d, rem)) ok = 1'b0;
    if (ok && rem > 1 && n < rem) ok = 1'b0;
    return ok;
  endfunction

  task automatic send_beat(input logic [W-1:0] n, input logic [W-1:0] m,
                           input bit known, input bit answer);
    int gap;
    gap = 0;
    while ($urandom_range(99) < idle_pct) gap++;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    n_value <= n;
    m_value <= m;
    do @(posedge clk); while (busy);
    pending_answers = {pending_answers, (known ? answer : factorial_divisible(n, m))};
  endtask

  always @(posedge clk) begin
    if (!rst && done) begin
      if (pending_answers.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result beat: divides=%0b", divides);
      end else begin
        bit want;
        want = pending_answers.pop_front();
        if (divides !== want) begin
          mismatches++;
          if (mismatches <= 10) $display("divides mismatch: expected %0b actual %0b", want, divides);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || done || (start && !busy)) stall_count <= 0;
    else if (stall_count >= STALL_LIMIT) begin
      $display("factorial_divisibility_test_core_test NOT OK");
      $finish;
    end else stall_count <= stall_count + 1;
  end

  divisibility_row_t table_rows[23] = '{
    '{W'(0), W'(1), 1'b1, 1'b1},
    '{W'(0), W'(0), 1'b1, 1'b0},
    '{W'(0), W'(2), 1'b1, 1'b0},
    '{W'(OP_MAX), W'(1), 1'b1, 1'b1},
    '{W'(OP_MAX), W'(0), 1'b1, 1'b0},
    '{W'(0), W'(OP_MAX), 1'b1, 1'b0},
    '{W'(1), W'(2), 1'b1, 1'b0},
    '{W'(2), W'(2), 1'b0, 1'b0},
    '{W'(5), W'(120), 1'b0, 1'b0},
    '{W'(4), W'(120), 1'b0, 1'b0},
    '{W'(10), W'(1024), 1'b0, 1'b0},
    '{W'(12), W'(1024), 1'b0, 1'b0},
    '{W'(OP_MAX), W'(1 << 30), 1'b0, 1'b0},
    '{W'(6), W'(49), 1'b0, 1'b0},
    '{W'(14), W'(49), 1'b0, 1'b0},
    '{W'(13), W'(13), 1'b0, 1'b0},
    '{W'(12), W'(13), 1'b0, 1'b0},
    '{W'(3), W'(3), 1'b0, 1'b0},
    '{W'(100), W'(9409), 1'b0, 1'b0},
    '{W'(193), W'(9409), 1'b0, 1'b0},
    '{W'(194), W'(9409), 1'b0, 1'b0},
    '{W'(OP_MAX), W'(OP_MAX), 1'b0, 1'b0},
    '{W'(65536), W'(65537 * 3), 1'b0, 1'b0}
  };

  initial begin
    logic [W-1:0] rn;
    logic [W-1:0] rm;
    rst = 1'b1;
    start = 1'b0;
    n_value = '0;
    m_value = '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    foreach (table_rows[i])
      send_beat(table_rows[i].n, table_rows[i].m, table_rows[i].known, table_rows[i].answer);
    for (int i = 0; i < RANDOM_BEATS; i++) begin
      case (i / 20)
        1: idle_pct = 74;
        3: idle_pct = 6;
        default: idle_pct = 0;
      endcase
      case ($urandom_range(2))
        0: rn = W'($urandom_range(40));
        1: rn = W'($urandom_range(2000));
        default: rn = W'($urandom);
      endcase
      case ($urandom_range(3))
        0: rm = W'($urandom_range(65535, 1));
        1: rm = W'($urandom_range(2000, 1));
        default: rm = W'(longint'($urandom_range(65535, 1)) << $urandom_range(15));
      endcase
      send_beat(rn, rm, 1'b0, 1'b0);
    end
    start <= 1'b0;
    while (pending_answers.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) $display("factorial_divisibility_test_core_test OK");
    else $display("factorial_divisibility_test_core_test NOT OK");
    $finish;
  end
endmodule

/* factorial_divisibility_test_core.f */
src/fdt_pkg.sv
src/fdt_serial_div.sv
src/factorial_divisibility_test_core.sv
src/fdt_checker.sv
sim/factorial_divisibility_test_core_test.sv
